[rtl/beat_pattern_scheduler_core_assert.svh]
// Assertion macros used by the beat pattern scheduler checker.
`ifndef BEAT_PATTERN_SCHEDULER_CORE_ASSERT_SVH
`define BEAT_PATTERN_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BPS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bps: same-cycle property failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define BPS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bps: next-cycle property failed");

`endif

[rtl/bps_pkg.sv]
// Package with types, constants and codes of the beat pattern scheduler.
package bps_pkg;

    // Default values of the top-level parameters.
    localparam int PATTERN_DEPTH_DEF  = 16;
    localparam int PRE_ROLL_TICKS_DEF = 50;
    localparam int TICK_HZ_DEF        = 1000;

    // Field and register widths.
    localparam int MODE_W    = 3;
    localparam int INDEX_W   = 4;
    localparam int SOUND_W   = 4;
    localparam int MULT_W    = 16;
    localparam int POS_W     = 4;
    localparam int BPM_W     = 10;
    localparam int LEN_W     = 5;
    localparam int COUNT_W   = 24;
    localparam int ENTRY_W   = SOUND_W + MULT_W;
    localparam int FRAC_W    = 8;

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = BPM_W;

    // Register reset values.
    localparam logic [BPM_W-1:0] BPM_RESET = BPM_W'(120);
    localparam logic [LEN_W-1:0] LEN_RESET = '0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BPM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN = 1'b1;

    // Item kinds carried on the input tuser.
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK    = 3'd0,
        MODE_LOAD    = 3'd1,
        MODE_START   = 3'd2,
        MODE_STOP    = 3'd3,
        MODE_RESTART = 3'd4
    } mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_LATCH,
        ST_MUL,
        ST_DIV,
        ST_RESULT
    } state_t;

    // Status and results of the serial divider.
    typedef struct packed {
        logic               done;
        logic               overflow;
        logic [COUNT_W-1:0] quotient;
        logic [BPM_W-1:0]   remainder;
    } div_res_t;

endpackage

[rtl/bps_ram.sv]
// Generic single-port-write, registered-read RAM.
module bps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/bps_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module bps_div #(
    parameter int DVD_W = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DVD_W-1:0]          dividend,
    input  logic [bps_pkg::BPM_W-1:0] divisor,
    output bps_pkg::div_res_t         res
);

    import bps_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [BPM_W-1:0]   dvs_reg, dvs_next;
    logic [BPM_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0] quo_reg, quo_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;

    logic [BPM_W:0] trial;
    logic [BPM_W:0] diff;
    logic           ge;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            quo_next = '0;
            ovf_next = 1'b0;
            cnt_next = CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next  = ge ? diff[BPM_W-1:0] : trial[BPM_W-1:0];
            quo_next  = {quo_reg[COUNT_W-2:0], ge};
            // A set bit pushed out of the top means the quotient saturates.
            ovf_next  = ovf_reg | quo_reg[COUNT_W-1];
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    // Status and results, packed in the order of the result type.
    assign res = {done_reg, ovf_reg, quo_reg, rem_reg};

endmodule

[rtl/beat_pattern_scheduler_core.sv]
// Non-firing items (load, start, stop, restart, quiet tick) go straight to the result state
// after acceptance; only one input transaction is in flight at a time.
// A firing tick runs the bit-serial divider twice (slot = position mod length, then the
// interval) before its result is loaded; a stalled result delays taking the next input.
// Reset clears control state and config (bpm 120, length 0), not the pattern memory.
module beat_pattern_scheduler_core #(
    parameter int PATTERN_DEPTH  = bps_pkg::PATTERN_DEPTH_DEF,
    parameter int PRE_ROLL_TICKS = bps_pkg::PRE_ROLL_TICKS_DEF,
    parameter int TICK_HZ        = bps_pkg::TICK_HZ_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: paused[0], entry_index[4:1], entry_sound[8:5], entry_multiplier[24:9], zero pad
    input  logic [bps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: mode[2:0]
    input  logic [bps_pkg::MODE_W-1:0]      s_axis_tuser,
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: beat[0], sound[4:1], position[8:5], zero pad
    output logic [bps_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import bps_pkg::*;

    localparam int AW       = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int TICKS_MIN = 60 * TICK_HZ;
    localparam int PROD_W   = MULT_W + $clog2(TICKS_MIN + 1);
    localparam int DVD_W    = PROD_W - FRAC_W;

    // Input field unpacking.
    logic               in_paused;
    logic [INDEX_W-1:0] in_index;
    logic [SOUND_W-1:0] in_sound;
    logic [MULT_W-1:0]  in_mult;
    mode_t              in_mode;

    assign in_paused = s_axis_tdata[0];
    assign in_index  = s_axis_tdata[4:1];
    assign in_sound  = s_axis_tdata[8:5];
    assign in_mult   = s_axis_tdata[24:9];
    assign in_mode   = mode_t'(s_axis_tuser);

    // Configuration registers.
    logic [BPM_W-1:0] bpm_reg, bpm_next;
    logic [LEN_W-1:0] len_reg, len_next;

    always_comb
    begin
        bpm_next = bpm_reg;
        len_next = len_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BPM: bpm_next = cfg_wdata;
                REG_LEN: len_next = cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpm_reg <= BPM_RESET;
            len_reg <= LEN_RESET;
        end
        else
        begin
            bpm_reg <= bpm_next;
            len_reg <= len_next;
        end
    end

    // Effective divisors: length clamped to the depth, zero bpm taken as one.
    logic [LEN_W-1:0] len_eff;
    logic [BPM_W-1:0] bpm_eff;

    assign len_eff = (32'(len_reg) > PATTERN_DEPTH) ? LEN_W'(PATTERN_DEPTH) : len_reg;
    assign bpm_eff = (bpm_reg == '0) ? BPM_W'(1) : bpm_reg;

    // Sequencer and datapath registers.
    state_t             state_reg, state_next;
    logic               running_reg, running_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]      bpos_reg, bpos_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               res_beat_reg, res_beat_next;
    logic [SOUND_W-1:0] res_sound_reg, res_sound_next;
    logic [POS_W-1:0]   res_pos_reg, res_pos_next;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // Divider and memory hookup.
    logic               div_start;
    logic [DVD_W-1:0]   div_dividend;
    logic [BPM_W-1:0]   div_divisor;
    div_res_t           div_res;
    logic               ram_we;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               s_accept;
    logic [COUNT_W-1:0] count_dec;
    logic [AW:0]        slot_inc;
    logic [COUNT_W-1:0] interval;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign count_dec     = count_reg - COUNT_W'(count_reg != '0);
    assign slot_inc      = {1'b0, slot_reg} + (AW+1)'(1);

    // Saturate the quotient and keep the interval at least one tick.
    assign interval = div_res.overflow ? COUNT_MAX :
                      ((div_res.quotient == '0) ? COUNT_W'(1) : div_res.quotient);

    // Operand select: position mod length at the tick, interval after the entry read.
    assign div_dividend = (state_reg == ST_MUL) ? prod_reg[PROD_W-1:FRAC_W]
                                                : DVD_W'(bpos_reg);
    assign div_divisor  = (state_reg == ST_MUL) ? bpm_eff : BPM_W'(len_eff);

    // Next state and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        running_next   = running_reg;
        count_next     = count_reg;
        bpos_next      = bpos_reg;
        slot_next      = slot_reg;
        prod_next      = prod_reg;
        res_beat_next  = res_beat_reg;
        res_sound_next = res_sound_reg;
        res_pos_next   = res_pos_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        ram_we         = 1'b0;

        // Output transaction completes.
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    res_beat_next  = 1'b0;
                    res_sound_next = '0;
                    res_pos_next   = '0;
                    state_next     = ST_RESULT;
                    case (in_mode)
                        MODE_TICK:
                        begin
                            if (running_reg && !in_paused)
                            begin
                                count_next = count_dec;
                                // Due beat with a non-empty pattern: find the slot first.
                                if (count_dec == '0 && len_eff != '0)
                                begin
                                    div_start  = 1'b1;
                                    state_next = ST_MOD;
                                end
                            end
                        end
                        MODE_LOAD:
                        begin
                            ram_we = (32'(in_index) < PATTERN_DEPTH);
                        end
                        MODE_START:
                        begin
                            running_next = 1'b1;
                            count_next   = COUNT_W'(PRE_ROLL_TICKS);
                            bpos_next    = '0;
                        end
                        MODE_STOP:
                        begin
                            running_next = 1'b0;
                        end
                        MODE_RESTART:
                        begin
                            bpos_next  = '0;
                            count_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOD:
            begin
                if (div_res.done)
                begin
                    slot_next  = AW'(div_res.remainder);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                res_beat_next  = 1'b1;
                res_sound_next = ram_rdata[ENTRY_W-1:MULT_W];
                res_pos_next   = POS_W'(slot_reg);
                prod_next      = PROD_W'(ram_rdata[MULT_W-1:0]) * PROD_W'(TICKS_MIN);
                bpos_next      = (32'(slot_inc) >= 32'(len_eff)) ? '0 : slot_inc[AW-1:0];
                state_next     = ST_MUL;
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    count_next = interval;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // Load the output register once it is free or being drained.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_W'({res_pos_reg, res_sound_reg, res_beat_reg});
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= 1'b0;
            count_reg     <= '0;
            bpos_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            count_reg     <= count_next;
            bpos_reg      <= bpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        prod_reg      <= prod_next;
        res_beat_reg  <= res_beat_next;
        res_sound_reg <= res_sound_next;
        res_pos_reg   <= res_pos_next;
        out_data_reg  <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Pattern memory: sound in the upper bits, Q8.8 multiplier below.
    bps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PATTERN_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_index)),
        .wdata ({in_sound, in_mult}),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Shared serial divider.
    bps_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

endmodule

[rtl/bps_checker.sv]
// Port-level checker for the beat pattern scheduler, bound to the top level.
`include "beat_pattern_scheduler_core_assert.svh"

module bps_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bps_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import bps_pkg::*;

    // A stalled result transaction keeps its data.
    `BPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // One item is worked at a time: no input is taken in the cycle after one is.
    `BPS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // Without a beat, sound and position read as zero.
    `BPS_ASSERT_IMP(a_quiet_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[8:1] == 8'd0)

    // Pad bits of the result are zero.
    `BPS_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:9] == '0)

endmodule

bind beat_pattern_scheduler_core bps_checker u_bps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
